@@ rtl/assert_macros.svh @@
// assertion macros shared by the cull core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define BSBC_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// antecedent this cycle implies consequent in the next cycle
`define BSBC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

@@ rtl/bsbc_pkg.sv @@
// types and constants of the box and swept box cull core
package bsbc_pkg;

	localparam int COORD_BITS   = 32;
	localparam int VEC_BITS     = 21;
	localparam int HALF_BITS    = 32;
	localparam int CFG_BITS     = 2 * HALF_BITS;
	localparam int ELEM_BITS    = 32;
	localparam int CFG_IDX_BITS = 3;
	localparam int DIFF_BITS    = COORD_BITS + 1;
	localparam int PROD_BITS    = DIFF_BITS + VEC_BITS + 1;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SCAN_X = 3'd0,
		REG_SCAN_Y = 3'd1,
		REG_SCAN_Z = 3'd2,
		REG_SKEW_X = 3'd3,
		REG_SKEW_Y = 3'd4,
		REG_SKEW_Z = 3'd5,
		REG_SWEEP  = 3'd6,
		REG_MODE   = 3'd7
	} reg_idx_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic [VEC_BITS-1:0]          vmag_t;

	typedef struct packed {
		coord_t [2:0] lo;
		coord_t [2:0] hi;
	} box_t;

	typedef struct packed {
		box_t          scan;
		box_t          skew;
		vmag_t [2:0]   vmag;
		logic  [2:0]   vneg;
		logic          is3d;
		logic          skew_en;
	} cfg_t;

	// verdict settled before the swept test
	typedef struct packed {
		logic decided;
		logic rej;
	} ctl_t;

	typedef struct packed {
		ctl_t         ctl;
		diff_t [2:0]  dlo;
		diff_t [2:0]  dhi;
	} s1_t;

	typedef struct packed {
		ctl_t  ctl;
		prod_t a1;
		prod_t b2;
		prod_t b1;
		prod_t a2;
		prod_t lo0_v2;
		prod_t hi2_v0;
		prod_t lo1_v2;
		prod_t hi2_v1;
		prod_t hi0_v2;
		prod_t lo2_v0;
		prod_t hi1_v2;
		prod_t lo2_v1;
	} s2_t;

endpackage

@@ rtl/bsbc_regs.sv @@
// configuration registers with sweep vector split into magnitude and sign
module bsbc_regs
	import bsbc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	output cfg_t                    cfg
);

	cfg_t        cfg_q;
	coord_t      wr_lo;
	coord_t      wr_hi;
	vmag_t [2:0] wr_mag;
	logic  [2:0] wr_neg;

	always_comb begin
		wr_lo = cfg_data[COORD_BITS-1:0];
		wr_hi = cfg_data[HALF_BITS +: COORD_BITS];
		for (int a = 0; a < 3; a++) begin
			wr_neg[a] = cfg_data[a*VEC_BITS + VEC_BITS - 1];
			wr_mag[a] = wr_neg[a] ? (~cfg_data[a*VEC_BITS +: VEC_BITS] + vmag_t'(1))
				: cfg_data[a*VEC_BITS +: VEC_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SCAN_X: begin
					cfg_q.scan.lo[0] <= wr_lo;
					cfg_q.scan.hi[0] <= wr_hi;
				end
				REG_SCAN_Y: begin
					cfg_q.scan.lo[1] <= wr_lo;
					cfg_q.scan.hi[1] <= wr_hi;
				end
				REG_SCAN_Z: begin
					cfg_q.scan.lo[2] <= wr_lo;
					cfg_q.scan.hi[2] <= wr_hi;
				end
				REG_SKEW_X: begin
					cfg_q.skew.lo[0] <= wr_lo;
					cfg_q.skew.hi[0] <= wr_hi;
				end
				REG_SKEW_Y: begin
					cfg_q.skew.lo[1] <= wr_lo;
					cfg_q.skew.hi[1] <= wr_hi;
				end
				REG_SKEW_Z: begin
					cfg_q.skew.lo[2] <= wr_lo;
					cfg_q.skew.hi[2] <= wr_hi;
				end
				REG_SWEEP: begin
					cfg_q.vmag <= wr_mag;
					cfg_q.vneg <= wr_neg;
				end
				REG_MODE: begin
					cfg_q.is3d    <= cfg_data[0];
					cfg_q.skew_en <= cfg_data[1];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/bsbc_front.sv @@
// stage one: box overlap tests and oriented distances
module bsbc_front
	import bsbc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 elem_valid,
	output logic                 elem_ready,
	input  logic [ELEM_BITS-1:0] elem_low_x,
	input  logic [ELEM_BITS-1:0] elem_low_y,
	input  logic [ELEM_BITS-1:0] elem_low_z,
	input  logic [ELEM_BITS-1:0] elem_high_x,
	input  logic [ELEM_BITS-1:0] elem_high_y,
	input  logic [ELEM_BITS-1:0] elem_high_z,
	output logic                 s1_valid,
	output s1_t                  s1_data,
	input  logic                 s1_ready
);

	coord_t [2:0] el;
	coord_t [2:0] eh;
	logic         miss_scan;
	logic         miss_skew;
	s1_t          d_next;
	logic         v_s1;
	s1_t          d_s1;

	// true when the element box lies outside box b on some axis
	function automatic logic box_miss(box_t b, coord_t [2:0] lo, coord_t [2:0] hi);
		logic m;
		m = 1'b0;
		for (int a = 0; a < 3; a++) begin
			m = m || ($signed(lo[a]) > $signed(b.hi[a])) || ($signed(hi[a]) < $signed(b.lo[a]));
		end
		return m;
	endfunction

	always_comb begin
		el[0] = elem_low_x[COORD_BITS-1:0];
		el[1] = elem_low_y[COORD_BITS-1:0];
		el[2] = cfg.is3d ? coord_t'(elem_low_z[COORD_BITS-1:0]) : '0;
		eh[0] = elem_high_x[COORD_BITS-1:0];
		eh[1] = elem_high_y[COORD_BITS-1:0];
		eh[2] = cfg.is3d ? coord_t'(elem_high_z[COORD_BITS-1:0]) : '0;

		miss_scan = box_miss(cfg.scan, el, eh);
		miss_skew = box_miss(cfg.skew, el, eh);

		if (!cfg.skew_en) begin
			d_next.ctl.decided = 1'b1;
			d_next.ctl.rej     = miss_scan;
		end else if (miss_scan) begin
			d_next.ctl.decided = 1'b1;
			d_next.ctl.rej     = 1'b1;
		end else if (!miss_skew) begin
			d_next.ctl.decided = 1'b1;
			d_next.ctl.rej     = 1'b0;
		end else begin
			d_next.ctl.decided = 1'b0;
			d_next.ctl.rej     = 1'b0;
		end

		// negative sweep component flips the interval: [lo, hi] -> [-hi, -lo]
		for (int a = 0; a < 3; a++) begin
			d_next.dlo[a] = cfg.vneg[a]
				? diff_t'($signed(cfg.skew.lo[a])) - diff_t'($signed(eh[a]))
				: diff_t'($signed(el[a])) - diff_t'($signed(cfg.skew.hi[a]));
			d_next.dhi[a] = cfg.vneg[a]
				? diff_t'($signed(cfg.skew.hi[a])) - diff_t'($signed(el[a]))
				: diff_t'($signed(eh[a])) - diff_t'($signed(cfg.skew.lo[a]));
		end
	end

	assign elem_ready = !v_s1 || s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (elem_ready) begin
			v_s1 <= elem_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (elem_ready) begin
			d_s1 <= d_next;
		end
	end

	assign s1_valid = v_s1;
	assign s1_data  = d_s1;

endmodule

@@ rtl/bsbc_mult.sv @@
// stage two: distance times sweep magnitude products
module bsbc_mult
	import bsbc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  vmag_t [2:0] vmag,
	input  logic        s1_valid,
	input  s1_t         s1_data,
	output logic        s1_ready,
	output logic        s2_valid,
	output s2_t         s2_data,
	input  logic        s2_ready
);

	s2_t  d_next;
	logic v_s2;
	s2_t  d_s2;

	// signed distance times unsigned magnitude
	function automatic prod_t mul_dv(diff_t d, vmag_t m);
		logic signed [VEC_BITS:0] ms;
		ms = {1'b0, m};
		return $signed(d) * ms;
	endfunction

	always_comb begin
		d_next.ctl    = s1_data.ctl;
		d_next.a1     = mul_dv(s1_data.dlo[0], vmag[1]);
		d_next.b2     = mul_dv(s1_data.dhi[1], vmag[0]);
		d_next.b1     = mul_dv(s1_data.dlo[1], vmag[0]);
		d_next.a2     = mul_dv(s1_data.dhi[0], vmag[1]);
		d_next.lo0_v2 = mul_dv(s1_data.dlo[0], vmag[2]);
		d_next.hi2_v0 = mul_dv(s1_data.dhi[2], vmag[0]);
		d_next.lo1_v2 = mul_dv(s1_data.dlo[1], vmag[2]);
		d_next.hi2_v1 = mul_dv(s1_data.dhi[2], vmag[1]);
		d_next.hi0_v2 = mul_dv(s1_data.dhi[0], vmag[2]);
		d_next.lo2_v0 = mul_dv(s1_data.dlo[2], vmag[0]);
		d_next.hi1_v2 = mul_dv(s1_data.dhi[1], vmag[2]);
		d_next.lo2_v1 = mul_dv(s1_data.dlo[2], vmag[1]);
	end

	assign s1_ready = !v_s2 || s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s1_ready) begin
			v_s2 <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready) begin
			d_s2 <= d_next;
		end
	end

	assign s2_valid = v_s2;
	assign s2_data  = d_s2;

endmodule

@@ rtl/bsbc_decide.sv @@
// stage three: swept test compares and the output register
module bsbc_decide
	import bsbc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s2_valid,
	input  s2_t  s2_data,
	output logic s2_ready,
	output logic res_valid,
	output logic reject,
	input  logic res_ready
);

	logic miss_xy;
	logic miss_lo;
	logic miss_hi;
	logic rej_d;
	logic v_s3;
	logic reject_s3;

	always_comb begin
		miss_xy = ($signed(s2_data.a1) > $signed(s2_data.b2))
			|| ($signed(s2_data.a2) < $signed(s2_data.b1));
		// the plane that binds the entry side picks the z check
		miss_lo = ($signed(s2_data.a1) > $signed(s2_data.b1))
			? ($signed(s2_data.lo0_v2) > $signed(s2_data.hi2_v0))
			: ($signed(s2_data.lo1_v2) > $signed(s2_data.hi2_v1));
		miss_hi = ($signed(s2_data.a2) < $signed(s2_data.b2))
			? ($signed(s2_data.hi0_v2) < $signed(s2_data.lo2_v0))
			: ($signed(s2_data.hi1_v2) < $signed(s2_data.lo2_v1));
		rej_d = s2_data.ctl.decided ? s2_data.ctl.rej : (miss_xy || miss_lo || miss_hi);
	end

	assign s2_ready = !v_s3 || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (s2_ready) begin
			v_s3 <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready) begin
			reject_s3 <= rej_d;
		end
	end

	assign res_valid = v_s3;
	assign reject    = reject_s3;

endmodule

@@ rtl/box_and_swept_box_cull_core.sv @@
// top level of the box and swept box cull core
// an accepted word passes the stage one, stage two and stage three registers before its reject bit shows
// throughput: one word per cycle while the output is taken, set by three register stages each able to advance
// each stage moves whenever its own register is empty or the next stage takes its word
// reset clears the stage valid bits and every configuration register to zero
// no memories, so no clearing pass after reset
module box_and_swept_box_cull_core
	import bsbc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration write port, the user must write it only while the core is idle; the core does not enforce this
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	// element box word
	input  logic                    elem_valid,
	output logic                    elem_ready,
	input  logic [ELEM_BITS-1:0]    elem_low_x,
	input  logic [ELEM_BITS-1:0]    elem_low_y,
	input  logic [ELEM_BITS-1:0]    elem_low_z,
	input  logic [ELEM_BITS-1:0]    elem_high_x,
	input  logic [ELEM_BITS-1:0]    elem_high_y,
	input  logic [ELEM_BITS-1:0]    elem_high_z,
	// reject word
	output logic                    res_valid,
	input  logic                    res_ready,
	output logic                    reject
);

`include "assert_macros.svh"

	cfg_t cfg;
	logic s1_valid;
	logic s1_ready;
	s1_t  s1_data;
	logic s2_valid;
	logic s2_ready;
	s2_t  s2_data;

	// scan box, skew box, sweep magnitude and sign, mode bits
	bsbc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage one: both overlap tests settle plain and skew verdicts,
	// and the swept distances are formed already flipped by sweep sign
	bsbc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.elem_valid  (elem_valid),
		.elem_ready  (elem_ready),
		.elem_low_x  (elem_low_x),
		.elem_low_y  (elem_low_y),
		.elem_low_z  (elem_low_z),
		.elem_high_x (elem_high_x),
		.elem_high_y (elem_high_y),
		.elem_high_z (elem_high_z),
		.s1_valid    (s1_valid),
		.s1_data     (s1_data),
		.s1_ready    (s1_ready)
	);

	// stage two: twelve parallel distance by magnitude products
	bsbc_mult u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.vmag     (cfg.vmag),
		.s1_valid (s1_valid),
		.s1_data  (s1_data),
		.s1_ready (s1_ready),
		.s2_valid (s2_valid),
		.s2_data  (s2_data),
		.s2_ready (s2_ready)
	);

	// stage three: product compares and the output register
	bsbc_decide u_decide (
		.clk       (clk),
		.arst_n    (arst_n),
		.s2_valid  (s2_valid),
		.s2_data   (s2_data),
		.s2_ready  (s2_ready),
		.res_valid (res_valid),
		.reject    (reject),
		.res_ready (res_ready)
	);

	// an accepted word always lands in stage one
	`BSBC_ASSERT_NEXT(a_s1_fill, elem_valid && elem_ready, s1_valid, "accepted word lost")

	// a stalled stage one word holds until stage two takes it
	`BSBC_ASSERT_NEXT(a_s1_hold, s1_valid && !s1_ready, s1_valid && $stable(s1_data),
		"stalled stage one word changed")

	// a taken output frees the whole chain back to the input
	`BSBC_ASSERT(a_ready_chain, res_ready |-> elem_ready, "input blocked while output drains")

	// without skew testing the verdict is settled in stage one
	`BSBC_ASSERT(a_plain_decided, s1_valid && !cfg.skew_en |-> s1_data.ctl.decided,
		"plain mode word sent to swept test")

endmodule
